// File: hw/rtl/assert_macros.svh
// assertion macros used by virtual_timer_multiplexer_unit.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed: forbidden condition seen");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication violated");

`endif

// File: hw/rtl/vtm_pkg.sv
// types and constants of the virtual timer multiplexer
package vtm_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int TIME_W = 32;
	localparam int LATE_W = TIME_W - 1;
	localparam int CMD_W  = 2;
	localparam int ID_W   = 4;
	localparam int KIND_W = 3;
	localparam int CNT_W  = SLOT_W + 1;
	localparam int RAM_W  = 2 * TIME_W;

	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;

	typedef enum logic [KIND_W-1:0] {
		KIND_STARTED   = 3'd0,
		KIND_FULL      = 3'd1,
		KIND_CANCELLED = 3'd2,
		KIND_IGNORED   = 3'd3,
		KIND_FIRED     = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

endpackage

// File: hw/rtl/vtm_if.sv
// request and result channel interfaces of the virtual timer multiplexer
interface vtm_req_if;
	logic                        valid;
	logic                        ready;
	logic [vtm_pkg::CMD_W-1:0]   cmd;
	logic [vtm_pkg::TIME_W-1:0]  duration;
	logic                        repeat_req;
	logic [vtm_pkg::ID_W-1:0]    slot_sel;

	modport source (output valid, cmd, duration, repeat_req, slot_sel, input ready);
	modport sink (input valid, cmd, duration, repeat_req, slot_sel, output ready);
endinterface

interface vtm_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [vtm_pkg::KIND_W-1:0]  kind;
	logic [vtm_pkg::ID_W-1:0]    slot_id;
	logic                        last;

	modport source (output valid, kind, slot_id, last, input ready);
	modport sink (input valid, kind, slot_id, last, output ready);
endinterface

// File: hw/rtl/vtm_ram.sv
// generic simple dual-port ram with registered read
module vtm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/virtual_timer_multiplexer_unit.sv
// Virtual timer multiplexer: SLOTS software timers share one 32-bit tick counter.
// Channel req carries one command per transaction (tick, start, cancel); channel
// rsp returns the results, last marks the final result of a command.
// Start and cancel are answered from the rsp register in the cycle after
// acceptance. Start picks the lowest free slot.
// A tick sweeps the expiry/period ram one slot per cycle; during the scan,
// due slots are reloaded or freed and sorted into an insertion queue (most
// overdue first, lower slot on ties); then the fired results are returned
// from the queue head in order and the unit returns to idle. A tick with
// nothing due gives no result. The sweep over the single ram read port sets
// the tick time.
// req.ready is high only when idle and the rsp register is free or draining.
// A stalled rsp holds its transaction and the queue waits; nothing is dropped.
// Reset (arst_n low) clears the time counter and frees all slots at once;
// the ram needs no clearing since an entry is used only while its slot is busy.
module virtual_timer_multiplexer_unit (
	input  logic      clk,
	input  logic      arst_n,
	vtm_req_if.sink   req,
	vtm_rsp_if.source rsp
);

	import vtm_pkg::*;

	state_t state_q, state_n;

	logic [TIME_W-1:0] now_q;
	logic [SLOTS-1:0]  busy_q;
	logic [SLOTS-1:0]  periodic_q;
	logic [CNT_W-1:0]  issue_cnt_q;
	logic              rd_vld_s1;
	logic [SLOT_W-1:0] rd_idx_s1;

	// sorted queue of fired slots
	logic [SLOTS-1:0]  q_vld_q;
	logic [LATE_W-1:0] q_late_q [SLOTS];
	logic [SLOT_W-1:0] q_slot_q [SLOTS];

	logic              out_vld_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [ID_W-1:0]   out_slot_q;
	logic              out_last_q;

	logic              out_free;
	logic              accept;
	logic              issue;
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	logic [RAM_W-1:0]  ram_wdata;
	logic [SLOT_W-1:0] ram_raddr;
	logic [RAM_W-1:0]  ram_rdata;

	logic [TIME_W-1:0] rd_exp;
	logic [TIME_W-1:0] rd_per;
	logic [TIME_W-1:0] late_full;
	logic              fire;
	logic              pop;

	logic              free_found;
	logic [SLOT_W-1:0] free_idx;
	logic              cancel_hit;

	vtm_ram #(
		.WIDTH (RAM_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_free  = !out_vld_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign accept    = req.valid && req.ready;

	assign rsp.valid   = out_vld_q;
	assign rsp.kind    = out_kind_q;
	assign rsp.slot_id = out_slot_q;
	assign rsp.last    = out_last_q;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!busy_q[i] && !free_found) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	assign cancel_hit = (int'(req.slot_sel) < SLOTS) && busy_q[SLOT_W'(req.slot_sel)];

	// scan stage: read data of slot rd_idx_s1 arrives this cycle
	assign rd_exp    = ram_rdata[TIME_W-1:0];
	assign rd_per    = ram_rdata[RAM_W-1:TIME_W];
	assign late_full = now_q - rd_exp;
	assign fire      = rd_vld_s1 && busy_q[rd_idx_s1] && !late_full[TIME_W-1];

	assign issue     = (state_q == ST_SCAN) && (issue_cnt_q < CNT_W'(SLOTS));
	assign ram_raddr = issue_cnt_q[SLOT_W-1:0];
	assign pop       = (state_q == ST_DRAIN) && q_vld_q[0] && out_free;

	// the write to slot k lands while slot k+1 is read, so no same-entry overlap
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_idx_s1;
		ram_wdata = {rd_per, rd_exp + rd_per};
		if (accept && req.cmd == CMD_START && free_found) begin
			ram_we    = 1'b1;
			ram_waddr = free_idx;
			ram_wdata = {req.duration, now_q + req.duration};
		end else if (fire && periodic_q[rd_idx_s1]) begin
			ram_we = 1'b1;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req.cmd == CMD_TICK) begin
					state_n = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (issue_cnt_q == CNT_W'(SLOTS)) begin
					state_n = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!q_vld_q[0]) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			busy_q      <= '0;
			periodic_q  <= '0;
			issue_cnt_q <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				issue_cnt_q <= issue_cnt_q + CNT_W'(1);
			end else if (state_q != ST_SCAN) begin
				issue_cnt_q <= '0;
			end
			if (fire && !periodic_q[rd_idx_s1]) begin
				busy_q[rd_idx_s1] <= 1'b0;
			end
			if (accept) begin
				unique case (req.cmd)
					CMD_TICK: now_q <= now_q + TIME_W'(1);
					CMD_START: begin
						if (free_found) begin
							busy_q[free_idx]     <= 1'b1;
							periodic_q[free_idx] <= req.repeat_req;
						end
					end
					CMD_CANCEL: begin
						if (cancel_hit) begin
							busy_q[SLOT_W'(req.slot_sel)]     <= 1'b0;
							periodic_q[SLOT_W'(req.slot_sel)] <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= ram_raddr;
	end

	// insertion queue: cell i takes the new entry at the first place whose late
	// is smaller (or empty); cells behind it shift down, equal lates stay ahead
	logic [SLOTS-1:0]  gt;
	logic [SLOTS-1:0]  gt_dn;
	logic [SLOTS-1:0]  vld_dn;
	logic [SLOTS-1:0]  vld_up;
	logic [LATE_W-1:0] late_dn [SLOTS];
	logic [LATE_W-1:0] late_up [SLOTS];
	logic [SLOT_W-1:0] slot_dn [SLOTS];
	logic [SLOT_W-1:0] slot_up [SLOTS];
	logic [SLOTS-1:0]  q_vld_n;
	logic [LATE_W-1:0] q_late_n [SLOTS];
	logic [SLOT_W-1:0] q_slot_n [SLOTS];

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			gt[i]      = !q_vld_q[i] || (q_late_q[i] < late_full[LATE_W-1:0]);
			gt_dn[i]   = 1'b0;
			vld_dn[i]  = 1'b0;
			late_dn[i] = '0;
			slot_dn[i] = '0;
			vld_up[i]  = 1'b0;
			late_up[i] = '0;
			slot_up[i] = '0;
		end
		for (int i = 1; i < SLOTS; i++) begin
			gt_dn[i]   = gt[i-1];
			vld_dn[i]  = q_vld_q[i-1];
			late_dn[i] = q_late_q[i-1];
			slot_dn[i] = q_slot_q[i-1];
		end
		for (int i = 0; i < SLOTS - 1; i++) begin
			vld_up[i]  = q_vld_q[i+1];
			late_up[i] = q_late_q[i+1];
			slot_up[i] = q_slot_q[i+1];
		end
		for (int i = 0; i < SLOTS; i++) begin
			q_vld_n[i]  = q_vld_q[i];
			q_late_n[i] = q_late_q[i];
			q_slot_n[i] = q_slot_q[i];
			if (fire) begin
				if (gt_dn[i]) begin
					q_vld_n[i]  = vld_dn[i];
					q_late_n[i] = late_dn[i];
					q_slot_n[i] = slot_dn[i];
				end else if (gt[i]) begin
					q_vld_n[i]  = 1'b1;
					q_late_n[i] = late_full[LATE_W-1:0];
					q_slot_n[i] = rd_idx_s1;
				end
			end else if (pop) begin
				q_vld_n[i]  = vld_up[i];
				q_late_n[i] = late_up[i];
				q_slot_n[i] = slot_up[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_vld_q <= '0;
		end else begin
			q_vld_q <= q_vld_n;
		end
	end

	always_ff @(posedge clk) begin
		q_late_q <= q_late_n;
		q_slot_q <= q_slot_n;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= pop || (accept && (req.cmd == CMD_START || req.cmd == CMD_CANCEL));
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_kind_q <= KIND_FIRED;
			out_slot_q <= ID_W'(q_slot_q[0]);
			out_last_q <= !q_vld_q[1];
		end else if (accept && req.cmd == CMD_START) begin
			out_kind_q <= free_found ? KIND_STARTED : KIND_FULL;
			out_slot_q <= free_found ? ID_W'(free_idx) : '0;
			out_last_q <= 1'b1;
		end else if (accept && req.cmd == CMD_CANCEL) begin
			out_kind_q <= cancel_hit ? KIND_CANCELLED : KIND_IGNORED;
			out_slot_q <= req.slot_sel;
			out_last_q <= 1'b1;
		end
	end

`include "assert_macros.svh"

	// queue entries are packed from the head
	`ASSERT_NEVER(a_queue_packed, clk, arst_n, (q_vld_q & (q_vld_q + SLOTS'(1))) != '0)
	// head is never less overdue than its successor
	`ASSERT_IMPLIES(a_queue_sorted, clk, arst_n, q_vld_q[1], q_late_q[0] >= q_late_q[1])
	// a non-final result always has a follower waiting in the queue
	`ASSERT_IMPLIES(a_more_follows, clk, arst_n, out_vld_q && !out_last_q,
		q_vld_q[0] && state_q == ST_DRAIN)
	// a reload during the scan only touches a busy slot
	`ASSERT_IMPLIES(a_reload_busy, clk, arst_n, ram_we && state_q == ST_SCAN,
		busy_q[ram_waddr] && periodic_q[ram_waddr])

endmodule
